[design/pidd_pkg.sv]
// ----------------------------------------------------------------------------
// pidd_pkg: shared types and constants for the position pid with integral decay
// Register indexes, decay codes, fixed field widths and reset values.
// ----------------------------------------------------------------------------
package pidd_pkg;

	// defaults for the top level parameters
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	// fixed field widths
	localparam int GAIN_W     = 16;
	localparam int ILIM_W     = 23;
	localparam int OLIM_W     = 15;
	localparam int INTEG_W    = 24;
	localparam int DRIVE_W    = 16;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [ILIM_W-1:0] ILIM_RESET = ILIM_W'(100000);
	localparam logic [OLIM_W-1:0] OLIM_RESET = OLIM_W'(9500);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		DECAY_NONE  = 2'd0,
		DECAY_SCALE = 2'd1,
		DECAY_CLEAR = 2'd2
	} decay_cmd_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic        [ILIM_W-1:0] integral_limit;
		logic        [OLIM_W-1:0] output_limit;
	} cfg_t;

endpackage

[design/pidd_cfg.sv]
// ----------------------------------------------------------------------------
// pidd_cfg: configuration register file
// Holds gains and limits, written through a plain write port.
// ----------------------------------------------------------------------------
module pidd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [pidd_pkg::CFG_IDX_W-1:0] index,
	input  logic [pidd_pkg::CFG_DATA_W-1:0] wdata,
	output pidd_pkg::cfg_t                 cfg
);
	import pidd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.integral_limit <= ILIM_RESET;
			cfg_q.output_limit   <= OLIM_RESET;
		end else if (we) begin
			// unused indexes are dropped
			unique case (index)
				REG_GAIN_P:         cfg_q.gain_p         <= $signed(wdata[GAIN_W-1:0]);
				REG_GAIN_I:         cfg_q.gain_i         <= $signed(wdata[GAIN_W-1:0]);
				REG_GAIN_D:         cfg_q.gain_d         <= $signed(wdata[GAIN_W-1:0]);
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= wdata[ILIM_W-1:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= wdata[OLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/position_pid_with_integral_decay_unit.sv]
// ----------------------------------------------------------------------------
// position_pid_with_integral_decay_unit: positional pid with clamped, decaying integral
// error = measured - setpoint; clamped integral with 3/4 or clear decay;
// drive = (kp*e + ki*i + kd*de) >>> frac bits, saturated to the output limit.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid / in_stall    | measured, setpoint, decay_cmd
//  out     | out_valid / out_stall  | drive
//  cfg     | cfg_we                 | cfg_index, cfg_wdata
//
//  one request per cycle sustained while the output is not stalled; a request
//  passes the input register, then integral update, three products, sum and clamp.
//  the integral update loop closes in a single stage, which sets the rate.
//  reset clears the pipeline valids, integral and previous error, and loads
//  the register defaults. a stalled output backs up stage by stage, empty
//  stages still take new requests.
//
module position_pid_with_integral_decay_unit #(
	parameter int SAMPLE_WIDTH   = pidd_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pidd_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]   measured,
	input  logic signed [SAMPLE_WIDTH-1:0]   setpoint,
	input  logic [pidd_pkg::CMD_W-1:0]       decay_cmd,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [pidd_pkg::DRIVE_W-1:0] drive,
	input  logic                             cfg_we,
	input  logic [pidd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import pidd_pkg::*;

	localparam int ERR_W  = SAMPLE_WIDTH + 1;
	localparam int DIFF_W = SAMPLE_WIDTH + 2;
	localparam int SUM_W  = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
	localparam int DEC_W  = INTEG_W + 2;
	localparam int PP_W   = GAIN_W + ERR_W;
	localparam int PI_W   = GAIN_W + INTEG_W;
	localparam int PD_W   = GAIN_W + DIFF_W;
	localparam int PMAX_W = (PP_W > PI_W) ? ((PP_W > PD_W) ? PP_W : PD_W)
	                                      : ((PI_W > PD_W) ? PI_W : PD_W);
	localparam int ACC_W  = PMAX_W + 2;

	cfg_t cfg;

	pidd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// flow control: a stage loads when empty or when its successor loads
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;
	logic v_s1, v_s2, v_s3, out_valid_q;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1: input register
	logic signed [SAMPLE_WIDTH-1:0] meas_s1, tgt_s1;
	logic [CMD_W-1:0]               cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			meas_s1 <= measured;
			tgt_s1  <= setpoint;
			cmd_s1  <= decay_cmd;
		end
	end

	// stage 2: error, integral update and derivative difference
	logic signed [ERR_W-1:0]   err_c;
	logic signed [SUM_W-1:0]   isum_c, ilim_c, iclamp_c;
	logic signed [DEC_W-1:0]   tri_c, tri_adj_c, quarter_c;
	logic signed [INTEG_W-1:0] integ_next_c;
	logic signed [DIFF_W-1:0]  diff_c;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [INTEG_W-1:0] integ_s2;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic                      fire_s2;

	assign fire_s2 = v_s1 && rdy_s2;

	always_comb begin
		err_c  = ERR_W'(meas_s1) - ERR_W'(tgt_s1);
		isum_c = SUM_W'(integ_q) + SUM_W'(err_c);
		ilim_c = $signed(SUM_W'(cfg.integral_limit));
		if (isum_c > ilim_c) begin
			iclamp_c = ilim_c;
		end else if (isum_c < -ilim_c) begin
			iclamp_c = -ilim_c;
		end else begin
			iclamp_c = isum_c;
		end
		// 3/4 scaling, truncated toward zero
		tri_c     = (DEC_W'(iclamp_c) <<< 1) + DEC_W'(iclamp_c);
		tri_adj_c = tri_c[DEC_W-1] ? tri_c + DEC_W'(3) : tri_c;
		quarter_c = tri_adj_c >>> 2;
		unique case (cmd_s1)
			DECAY_SCALE: integ_next_c = quarter_c[INTEG_W-1:0];
			DECAY_CLEAR: integ_next_c = '0;
			default:     integ_next_c = iclamp_c[INTEG_W-1:0];
		endcase
		diff_c = DIFF_W'(err_c) - DIFF_W'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			integ_q    <= '0;
			prev_err_q <= '0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (fire_s2) begin
				integ_q    <= integ_next_c;
				prev_err_q <= err_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			err_s2   <= err_c;
			integ_s2 <= integ_next_c;
			diff_s2  <= diff_c;
		end
	end

	// stage 3: the three gain products
	logic signed [PP_W-1:0] prod_p_s3;
	logic signed [PI_W-1:0] prod_i_s3;
	logic signed [PD_W-1:0] prod_d_s3;
	logic                   fire_s3;

	assign fire_s3 = v_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s3) begin
			prod_p_s3 <= cfg.gain_p * err_s2;
			prod_i_s3 <= cfg.gain_i * integ_s2;
			prod_d_s3 <= cfg.gain_d * diff_s2;
		end
	end

	// output: sum, floor shift, saturate
	logic signed [ACC_W-1:0]   acc_c, shifted_c, olim_c, sat_c;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      fire_out;

	assign fire_out = v_s3 && rdy_out;

	always_comb begin
		acc_c     = ACC_W'(prod_p_s3) + ACC_W'(prod_i_s3) + ACC_W'(prod_d_s3);
		shifted_c = acc_c >>> GAIN_FRAC_BITS;
		olim_c    = $signed(ACC_W'(cfg.output_limit));
		if (shifted_c > olim_c) begin
			sat_c = olim_c;
		end else if (shifted_c < -olim_c) begin
			sat_c = -olim_c;
		end else begin
			sat_c = shifted_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_out) begin
			drive_q <= sat_c[DRIVE_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// a clear command leaves the integral at zero
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 && cmd_s1 == DECAY_CLEAR |=> integ_q == '0)
		else $error("integral not cleared");

	// previous error follows the request that moved into stage 2
	a_prev_err: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 |=> prev_err_q == err_s2)
		else $error("previous error out of step");

	// an empty output register never blocks the input
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled with output free");

	// saturation keeps the drive off the most negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> drive_q != {1'b1, {(DRIVE_W-1){1'b0}}})
		else $error("drive outside saturation range");

endmodule
